// ===== src/sto_pkg.sv =====
`default_nettype none
package sto_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAX_OUT    = 16;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);
    localparam int LEARN_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0] KIND_CC = 4'hb;

    localparam logic [1:0] FUNC_MIDI   = 2'd0;
    localparam logic [1:0] FUNC_ASSIGN = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_MASK   = 1'd1;

    localparam logic [7:0] NUM_UNASSIGNED = 8'h80;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ASSIGN,
        OP_CLEAR,
        OP_WALK
    } t_op;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [3:0] slot_index;
        logic [6:0] new_number;
        logic       number_valid;
    } t_in_item;

    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
        logic [6:0] value;
        logic [6:0] sync_gap;
        logic       value_changed;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [3:0] slot_index;
        logic [6:0] new_number;
        logic       number_valid;
    } t_cmd;

    function automatic logic [6:0] dist7(input logic [6:0] a, input logic [6:0] b);
        logic [6:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== src/midi_cc_soft_takeover_unit.sv =====
`default_nettype none
// Channel    Ports                              Transaction
// input      push, full, i_item                 push && !full
// result     empty, pop, o_result               pop && !empty
// config     i_cfg_we, i_cfg_idx, i_cfg_data    i_cfg_we, no wait
//
// A control-change item walks the slots one per cycle unless a stall holds it:
// take the command, walk up to SLOT_COUNT slots, emit the final result. Assign
// takes, assigns and emits; reset-all and ignored items take and emit.
// Synchronous active-low reset restores slot numbers, values and sync state.
// A two-entry command queue keeps input taking items while the slot walker
// waits on a full result register; the walk holds in place when a further hit
// finds the result register full and pop low.
module midi_cc_soft_takeover_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [sto_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [sto_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           push,
    output logic                          full,
    input  sto_pkg::t_in_item              i_item,
    output logic                          empty,
    input  wire                           pop,
    output sto_pkg::t_out_item             o_result
);
    import sto_pkg::*;

    logic               cmd_push;
    t_cmd               cmd_in;
    t_cmd               cmd_head;
    logic               cmd_empty;
    logic               cmd_pop;
    logic [LEARN_W-1:0] learn_mask;

    sto_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .o_learn_mask (learn_mask),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    sto_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_head)
    );

    sto_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (cmd_empty),
        .i_cmd        (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_learn_mask (learn_mask),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire

// ===== src/sto_front.sv =====
`default_nettype none
module sto_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [sto_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [sto_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           i_push,
    input  wire                           i_full,
    input  sto_pkg::t_in_item              i_item,
    output logic [sto_pkg::LEARN_W-1:0]    o_learn_mask,
    output logic                          o_cmd_push,
    output sto_pkg::t_cmd                  o_cmd
);
    import sto_pkg::*;

    logic [4:0]         r_midi_channel;
    logic [LEARN_W-1:0] r_learn_mask;
    logic               chan_ok;
    logic               is_cc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_channel <= 5'h1f;
            r_learn_mask   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIDI_CHANNEL: r_midi_channel <= i_cfg_data[4:0];
                CFG_LEARN_MASK:   r_learn_mask   <= i_cfg_data[LEARN_W-1:0];
                default: ;
            endcase
        end
    end

    // negative channel setting accepts every channel
    assign chan_ok = r_midi_channel[4] || (r_midi_channel[3:0] == i_item.status_byte[3:0]);
    assign is_cc   = (i_item.status_byte[7:4] == KIND_CC);

    always_comb begin
        o_cmd.data_one     = i_item.data_one;
        o_cmd.data_two     = i_item.data_two;
        o_cmd.slot_index   = i_item.slot_index;
        o_cmd.new_number   = i_item.new_number;
        o_cmd.number_valid = i_item.number_valid;
        case (i_item.func)
            FUNC_MIDI:   o_cmd.op = (chan_ok && is_cc) ? OP_WALK : OP_NONE;
            FUNC_ASSIGN: o_cmd.op = (32'(i_item.slot_index) < 32'(SLOT_COUNT)) ?
                                    OP_ASSIGN : OP_NONE;
            FUNC_CLEAR:  o_cmd.op = OP_CLEAR;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    assign o_cmd_push   = i_push && !i_full;
    assign o_learn_mask = r_learn_mask;

endmodule
`default_nettype wire

// ===== src/sto_cmd_fifo.sv =====
`default_nettype none
module sto_cmd_fifo (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  sto_pkg::t_cmd  i_cmd,
    output logic          o_full,
    input  wire           i_pop,
    output logic          o_empty,
    output sto_pkg::t_cmd  o_cmd
);
    import sto_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== src/sto_back.sv =====
`default_nettype none
module sto_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cmd_empty,
    input  sto_pkg::t_cmd               i_cmd,
    output logic                       o_cmd_pop,
    input  wire  [sto_pkg::LEARN_W-1:0] i_learn_mask,
    output logic                       o_empty,
    input  wire                        i_pop,
    output sto_pkg::t_out_item          o_result
);
    import sto_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ASSIGN,
        S_WALK,
        S_FLUSH
    } t_state;

    logic [7:0] r_num   [SLOT_COUNT];
    logic [6:0] r_val   [SLOT_COUNT];
    logic [6:0] r_gap   [SLOT_COUNT];
    logic       r_first [SLOT_COUNT];

    t_state      r_state;
    t_cmd        r_cmd;
    logic [SLOT_W-1:0] r_idx;
    logic [CNT_W-1:0]  r_n;
    logic        r_pend_vld;
    t_out_item   r_pend;
    logic        r_out_vld;
    t_out_item   r_out;

    logic [7:0]  cur_num;
    logic [6:0]  cur_val;
    logic [6:0]  cur_gap;
    logic        cur_first;
    logic        learn;
    logic [7:0]  w_num;
    logic [6:0]  w_val;
    logic [6:0]  w_gap;
    logic        w_first;
    logic [6:0]  meas_gap;
    logic        match;
    logic        stop;
    logic        chg;
    logic        report;
    logic        push_need;
    logic        out_free;
    logic        stall;
    logic        walk_we;
    logic        clear_all;
    logic        out_load;
    t_out_item   hit_res;
    t_out_item   fin_res;

    assign out_free  = !r_out_vld || i_pop;
    assign o_empty   = !r_out_vld;
    assign o_result  = r_out;
    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign clear_all = o_cmd_pop && (i_cmd.op == OP_CLEAR);
    assign out_load  = ((r_state == S_WALK) && push_need && !stall) ||
                       ((r_state == S_FLUSH) && out_free);

    // pickup rules for the slot under the walk pointer
    always_comb begin
        cur_num   = r_num[r_idx];
        cur_val   = r_val[r_idx];
        cur_gap   = r_gap[r_idx];
        cur_first = r_first[r_idx];
        learn     = (32'(r_idx) < 32'(LEARN_W)) && i_learn_mask[4'(r_idx)];
        w_num     = learn ? {1'b0, r_cmd.data_one} : cur_num;
        w_first   = learn || cur_first;
        w_gap     = learn ? 7'd0 : cur_gap;
        w_val     = cur_val;
        meas_gap  = dist7(r_cmd.data_two, cur_val);
        match     = (w_num == {1'b0, r_cmd.data_one});
        stop      = 1'b0;
        chg       = 1'b0;
        if (match) begin
            if (w_first) begin
                w_first = 1'b0;
                w_gap   = (meas_gap <= 7'd1) ? 7'd0 : meas_gap;
                stop    = 1'b1;
            end else if (w_gap == 7'd0) begin
                w_val = r_cmd.data_two;
                chg   = 1'b1;
            end else begin
                w_gap = meas_gap;
            end
        end
        hit_res.hit           = 1'b1;
        hit_res.slot          = 4'(r_idx);
        hit_res.value         = w_val;
        hit_res.sync_gap      = w_gap;
        hit_res.value_changed = chg;
        hit_res.last          = 1'b0;
        report    = match && (32'(r_n) < 32'(MAX_OUT));
        // an earlier hit is released only once a newer one proves it is not the final one
        push_need = report && r_pend_vld;
        stall     = push_need && !out_free;
        walk_we   = (r_state == S_WALK) && !stall;
        // final transaction: the held hit or assign report, else an empty report
        fin_res = '0;
        if (r_pend_vld) begin
            fin_res = r_pend;
        end
        fin_res.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_num[i]   <= 8'(i);
                r_val[i]   <= 7'd0;
                r_gap[i]   <= 7'd0;
                r_first[i] <= 1'b1;
            end
        end else if (clear_all) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_val[i]   <= 7'd0;
                r_gap[i]   <= 7'd0;
                r_first[i] <= 1'b1;
            end
        end else if (walk_we) begin
            r_num[r_idx]   <= w_num;
            r_val[r_idx]   <= w_val;
            r_gap[r_idx]   <= w_gap;
            r_first[r_idx] <= w_first;
        end else if (r_state == S_ASSIGN) begin
            if (r_cmd.number_valid) begin
                r_num[r_idx]   <= {1'b0, r_cmd.new_number};
                r_gap[r_idx]   <= 7'd0;
                r_first[r_idx] <= 1'b1;
            end else begin
                r_num[r_idx] <= NUM_UNASSIGNED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_n        <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd      <= i_cmd;
                        r_n        <= '0;
                        r_pend_vld <= 1'b0;
                        case (i_cmd.op)
                            OP_ASSIGN: begin
                                r_idx   <= SLOT_W'(i_cmd.slot_index);
                                r_state <= S_ASSIGN;
                            end
                            OP_WALK: begin
                                r_idx   <= '0;
                                r_state <= S_WALK;
                            end
                            default: begin
                                r_state <= S_FLUSH;
                            end
                        endcase
                    end
                end
                S_ASSIGN: begin
                    r_pend.hit           <= 1'b0;
                    r_pend.slot          <= 4'(r_idx);
                    r_pend.value         <= cur_val;
                    r_pend.sync_gap      <= r_cmd.number_valid ? 7'd0 : cur_gap;
                    r_pend.value_changed <= 1'b0;
                    r_pend.last          <= 1'b0;
                    r_pend_vld           <= 1'b1;
                    r_state              <= S_FLUSH;
                end
                S_WALK: begin
                    if (!stall) begin
                        if (push_need) begin
                            r_out <= r_pend;
                        end
                        if (report) begin
                            r_pend     <= hit_res;
                            r_pend_vld <= 1'b1;
                            r_n        <= r_n + CNT_W'(1);
                        end
                        if (stop || (r_idx == SLOT_W'(SLOT_COUNT - 1))) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx <= r_idx + SLOT_W'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_out      <= fin_res;
                        r_pend_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== tb/midi_cc_soft_takeover_unit_test.sv =====
`default_nettype none
module midi_cc_soft_takeover_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sto_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int REPORT_MAX   = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_out_item             o_result;

    midi_cc_soft_takeover_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    // Slot state and register copies for prediction
    logic [7:0] slot_num   [SLOT_COUNT];
    logic [6:0] slot_val   [SLOT_COUNT];
    logic [6:0] slot_gap   [SLOT_COUNT];
    bit         slot_first [SLOT_COUNT];
    logic [4:0] chan_reg;
    logic [15:0] learn_reg;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];

    int  queued_cnt;
    int  accepted_cnt;
    int  fail_count;
    int  stall_cnt;
    bit  in_fire;
    bit  out_fire;
    int  burst_left;
    int  gap_left;
    int  rx_mode;
    int  rx_stall;
    int  rx_cycle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [6:0] abs_diff7(input logic [6:0] a, input logic [6:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic predict_takeover(input t_in_item it);
        t_out_item res;
        t_out_item walk_q[$];
        logic [6:0] d;
        bit stop;
        bit chg;
        int i;
        res  = '0;
        stop = 1'b0;
        case (it.func)
            FUNC_ASSIGN: begin
                if (it.number_valid) begin
                    slot_num[it.slot_index]   = {1'b0, it.new_number};
                    slot_gap[it.slot_index]   = '0;
                    slot_first[it.slot_index] = 1'b1;
                end else begin
                    slot_num[it.slot_index] = NUM_UNASSIGNED;
                end
                res.slot     = it.slot_index;
                res.value    = slot_val[it.slot_index];
                res.sync_gap = slot_gap[it.slot_index];
            end
            FUNC_CLEAR: begin
                for (i = 0; i < SLOT_COUNT; i++) begin
                    slot_val[i]   = '0;
                    slot_gap[i]   = '0;
                    slot_first[i] = 1'b1;
                end
            end
            FUNC_MIDI: begin
                if ((chan_reg[4] || chan_reg[3:0] == it.status_byte[3:0]) &&
                    it.status_byte[7:4] == KIND_CC) begin
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        if (!stop) begin
                            chg = 1'b0;
                            if (learn_reg[i]) begin
                                slot_gap[i]   = '0;
                                slot_first[i] = 1'b1;
                                slot_num[i]   = {1'b0, it.data_one};
                            end
                            if (slot_num[i] == {1'b0, it.data_one}) begin
                                d = abs_diff7(it.data_two, slot_val[i]);
                                // first value after a sync reset only measures, then halts the walk
                                if (slot_first[i]) begin
                                    slot_first[i] = 1'b0;
                                    slot_gap[i]   = (d <= 1) ? 7'd0 : d;
                                    stop          = 1'b1;
                                end else if (slot_gap[i] == 0) begin
                                    slot_val[i] = it.data_two;
                                    chg         = 1'b1;
                                end else begin
                                    slot_gap[i] = d;
                                end
                                res.hit           = 1'b1;
                                res.slot          = 4'(i);
                                res.value         = slot_val[i];
                                res.sync_gap      = slot_gap[i];
                                res.value_changed = chg;
                                res.last          = 1'b0;
                                walk_q.push_back(res);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (walk_q.size() == 0)
            walk_q.push_back(res);
        foreach (walk_q[k]) begin
            res      = walk_q[k];
            res.last = (k == walk_q.size() - 1);
            expected_results.push_back(res);
        end
    endtask

    task automatic note_failure(input string what, input t_out_item want,
                                input t_out_item got);
        string exp_s;
        string got_s;
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            exp_s = $sformatf("hit=%0d slot=%0d value=%0d gap=%0d chg=%0d last=%0d",
                              want.hit, want.slot, want.value, want.sync_gap,
                              want.value_changed, want.last);
            got_s = $sformatf("hit=%0d slot=%0d value=%0d gap=%0d chg=%0d last=%0d",
                              got.hit, got.slot, got.value, got.sync_gap,
                              got.value_changed, got.last);
            $display("%0t %s: exp %s | got %s", $realtime, what, exp_s, got_s);
        end
    endtask

    // Monitor: predict on accepted items, check accepted results, watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        in_fire  = i_rst_n && push && !full;
        out_fire = i_rst_n && pop && !empty;
        if (in_fire) begin
            predict_takeover(i_item);
            accepted_cnt++;
        end
        if (out_fire) begin
            if (expected_results.size() == 0) begin
                note_failure("result with nothing pending", '0, o_result);
            end else begin
                want = expected_results.pop_front();
                if (o_result.hit !== want.hit || o_result.slot !== want.slot ||
                    o_result.value !== want.value || o_result.sync_gap !== want.sync_gap ||
                    o_result.value_changed !== want.value_changed ||
                    o_result.last !== want.last)
                    note_failure("mismatch", want, o_result);
            end
        end
        if (in_fire || out_fire)
            stall_cnt = 0;
        else if (accepted_cnt != queued_cnt || expected_results.size() != 0)
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            i_item <= '0;
        end else if (!push || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_items.size() != 0) begin
                push   <= 1'b1;
                i_item <= pending_items.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left--;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: switch stall style periodically
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 150 == 0)
                rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: begin
                    if (rx_stall != 0) begin
                        rx_stall--;
                        pop <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        rx_stall = $urandom_range(1, 20);
                        pop <= 1'b0;
                    end else begin
                        pop <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic add_item(input t_in_item it);
        pending_items.push_back(it);
        queued_cnt++;
    endtask

    function automatic t_in_item mk_cc(input logic [7:0] status, input logic [6:0] d1,
                                       input logic [6:0] d2);
        t_in_item it;
        it             = '0;
        it.func        = FUNC_MIDI;
        it.status_byte = status;
        it.data_one    = d1;
        it.data_two    = d2;
        return it;
    endfunction

    function automatic t_in_item mk_assign(input logic [3:0] idx, input logic [6:0] num,
                                           input logic valid);
        t_in_item it;
        it              = '0;
        it.func         = FUNC_ASSIGN;
        it.slot_index   = idx;
        it.new_number   = num;
        it.number_valid = valid;
        return it;
    endfunction

    function automatic t_in_item mk_func(input logic [1:0] f);
        t_in_item it;
        it      = '0;
        it.func = f;
        return it;
    endfunction

    // Mostly a small pool so that slots share numbers and walks report several hits
    function automatic logic [6:0] pick_number();
        return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 19));
    endfunction

    function automatic logic [7:0] cc_status();
        logic [3:0] ch;
        if (!chan_reg[4] && $urandom_range(0, 6) != 0)
            ch = chan_reg[3:0];
        else
            ch = 4'($urandom_range(0, 15));
        return {KIND_CC, ch};
    endfunction

    task automatic add_random(input int count);
        int made;
        int r;
        int len;
        int v;
        int target;
        int step;
        logic [6:0] num;
        logic [63:0] raw;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // knob sweep towards a target, which may cross the held value on the way
                num    = pick_number();
                v      = $urandom_range(0, 127);
                target = $urandom_range(0, 127);
                len    = $urandom_range(3, 10);
                if (len > count - made)
                    len = count - made;
                step   = $urandom_range(1, 2);
                repeat (len) begin
                    add_item(mk_cc(cc_status(), num, 7'(v)));
                    made++;
                    if (v < target)
                        v = (v + step > target) ? target : v + step;
                    else if (v > target)
                        v = (v - step < target) ? target : v - step;
                    else
                        target = $urandom_range(0, 127);
                end
            end else if (r < 75) begin
                add_item(mk_assign(4'($urandom_range(0, 15)), pick_number(),
                                   $urandom_range(0, 4) != 0));
                made++;
            end else if (r < 80) begin
                add_item(mk_func(FUNC_CLEAR));
                made++;
            end else if (r < 84) begin
                raw = {$urandom, $urandom};
                raw[$bits(t_in_item)-1 -: 2] = 2'b11;
                add_item(raw[$bits(t_in_item)-1:0]);
                made++;
            end else begin
                raw = {$urandom, $urandom};
                add_item(raw[$bits(t_in_item)-1:0]);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (accepted_cnt != queued_cnt || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MIDI_CHANNEL)
            chan_reg = data[4:0];
        else
            learn_reg = data;
    endtask

    task automatic start_phase(input logic [4:0] ch, input logic [15:0] mask);
        wait_idle();
        write_reg(CFG_MIDI_CHANNEL, {11'd0, ch});
        write_reg(CFG_LEARN_MASK, mask);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        push       = 1'b0;
        pop        = 1'b0;
        i_item     = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_num[i]   = 8'(i);
            slot_val[i]   = '0;
            slot_gap[i]   = '0;
            slot_first[i] = 1'b1;
        end
        chan_reg   = 5'h1f;
        learn_reg  = '0;
        burst_left = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // all channels, no learning
        start_phase(5'h1f, 16'h0000);
        add_item(mk_cc(8'hb0, 7'd0, 7'd0));
        add_item(mk_cc(8'hb0, 7'd0, 7'd127));
        add_item(mk_cc(8'hbf, 7'd127, 7'd1));
        add_item(mk_cc(8'h90, 7'd0, 7'd64));
        add_item(mk_cc(8'hff, 7'd15, 7'd64));
        add_item(mk_cc(8'h00, 7'd0, 7'd0));
        add_item(mk_assign(4'd15, 7'd127, 1'b1));
        add_item(mk_cc(8'hbf, 7'd127, 7'd1));
        add_item(mk_cc(8'hb5, 7'd127, 7'd127));
        add_item(mk_assign(4'd0, 7'd127, 1'b0));
        add_item(mk_cc(8'hb0, 7'd0, 7'd5));
        add_item('1);
        add_item(mk_func(FUNC_CLEAR));
        add_item(mk_cc(8'hb3, 7'd127, 7'd100));
        add_item(mk_cc(8'hb3, 7'd127, 7'd50));
        add_item(mk_cc(8'hb3, 7'd127, 7'd0));
        add_item(mk_cc(8'hb3, 7'd127, 7'd126));
        add_item(mk_assign(4'd3, 7'd127, 1'b1));
        add_item(mk_cc(8'hb7, 7'd127, 7'd126));
        add_item(mk_cc(8'hb7, 7'd127, 7'd0));
        add_random(100);

        // single channel, every slot learning
        start_phase(5'd15, 16'hffff);
        add_item(mk_cc(8'hbf, 7'd5, 7'd9));
        add_item(mk_cc(8'hb0, 7'd5, 7'd9));
        add_item(mk_cc(8'hbf, 7'd127, 7'd0));
        add_random(40);

        // channel 0; hold the sender until everything has drained half way
        start_phase(5'd0, 16'h0000);
        add_random(40);
        wait_idle();
        add_random(40);

        start_phase(5'($urandom_range(0, 15)),
                    16'((1 << $urandom_range(0, 15)) | (1 << $urandom_range(0, 15))));
        add_random(60);

        start_phase(5'h1f, 16'h8000);
        add_random(50);

        wait_idle();
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/sto_pkg.sv
src/sto_front.sv
src/sto_cmd_fifo.sv
src/sto_back.sv
src/midi_cc_soft_takeover_unit.sv
tb/midi_cc_soft_takeover_unit_test.sv
